>>> hdl/whpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whpd_pkg
// shared types and constants for the wav header parser and deinterleaver
// ----------------------------------------------------------------------------
package whpd_pkg;

    // result kinds
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // header error codes
    localparam logic [2:0] ERR_RIFF_ID  = 3'd0;
    localparam logic [2:0] ERR_SIZE     = 3'd1;
    localparam logic [2:0] ERR_WAVE     = 3'd2;
    localparam logic [2:0] ERR_FMT_ID   = 3'd3;
    localparam logic [2:0] ERR_FORMAT   = 3'd4;
    localparam logic [2:0] ERR_CHANNELS = 3'd5;
    localparam logic [2:0] ERR_BITS     = 3'd6;
    localparam logic [2:0] ERR_DATA_ID  = 3'd7;

    // chunk magics as they appear little-endian in the shift register
    localparam logic [31:0] MAGIC_RIFF = 32'h4646_4952;
    localparam logic [31:0] MAGIC_WAVE = 32'h4556_4157;
    localparam logic [31:0] MAGIC_FMT  = 32'h2074_6d66;
    localparam logic [31:0] MAGIC_DATA = 32'h6174_6164;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  error_code;
        logic        channel;
        logic [15:0] sample_value;
        logic [1:0]  channel_count;
        logic [4:0]  bits_per_sample;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [31:0] chunk_size;
        logic        last;
    } whpd_result_t;

endpackage

>>> hdl/wav_header_parse_deinterleave.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_header_parse_deinterleave
// parses a 44-byte pcm wav header from a byte stream and emits samples
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  input   | in        | in_valid/in_stall   | data_byte, start_req, file_size
//  output  | out       | out_valid/out_stall | kind .. last (header or sample)
//
//  one byte is taken every cycle unless in_stall; its result, if any, is registered
//  the parser state updates once per accepted byte, the frame count is a shift
//  in_stall comes straight from the skid entry flop, so it is registered
//  in_stall rises only after the output has been stalled with a result pending
//  rst_n clears the parser to idle and empties the output stage
// ----------------------------------------------------------------------------
module wav_header_parse_deinterleave
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        start_req,
    input  logic [31:0] file_size,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [2:0]  error_code,
    output logic        channel,
    output logic [15:0] sample_value,
    output logic [1:0]  channel_count,
    output logic [4:0]  bits_per_sample,
    output logic [31:0] sample_rate,
    output logic [31:0] byte_rate,
    output logic [15:0] block_align,
    output logic [31:0] chunk_size,
    output logic        last
);
    import whpd_pkg::*;

    logic         in_fire;
    logic         res_valid;
    logic         skid_full;
    whpd_result_t res;
    whpd_result_t out_data;

    assign in_stall = skid_full;
    assign in_fire  = in_valid & ~skid_full;

    whpd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (in_fire),
        .data_byte (data_byte),
        .start_req (start_req),
        .file_size (file_size),
        .res_valid (res_valid),
        .res       (res)
    );

    whpd_out_skid u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (skid_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign kind            = out_data.kind;
    assign error_code      = out_data.error_code;
    assign channel         = out_data.channel;
    assign sample_value    = out_data.sample_value;
    assign channel_count   = out_data.channel_count;
    assign bits_per_sample = out_data.bits_per_sample;
    assign sample_rate     = out_data.sample_rate;
    assign byte_rate       = out_data.byte_rate;
    assign block_align     = out_data.block_align;
    assign chunk_size      = out_data.chunk_size;
    assign last            = out_data.last;

endmodule

>>> hdl/whpd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whpd_parser
// per-byte header parse and sample deinterleave, one byte per cycle on fire
// ----------------------------------------------------------------------------
module whpd_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [7:0]            data_byte,
    input  logic                  start_req,
    input  logic [31:0]           file_size,
    output logic                  res_valid,
    output whpd_pkg::whpd_result_t res
);
    import whpd_pkg::*;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;

    localparam logic [5:0] POS_RIFF     = 6'd3;
    localparam logic [5:0] POS_SIZE     = 6'd7;
    localparam logic [5:0] POS_WAVE     = 6'd11;
    localparam logic [5:0] POS_FMT      = 6'd15;
    localparam logic [5:0] POS_FORMAT   = 6'd21;
    localparam logic [5:0] POS_CHANNELS = 6'd23;
    localparam logic [5:0] POS_RATE     = 6'd27;
    localparam logic [5:0] POS_BYTERATE = 6'd31;
    localparam logic [5:0] POS_ALIGN    = 6'd33;
    localparam logic [5:0] POS_BITS     = 6'd35;
    localparam logic [5:0] POS_DATA_ID  = 6'd39;
    localparam logic [5:0] POS_LAST     = 6'd43;

    logic [1:0]  phase_reg,    phase_next;
    logic [5:0]  pos_reg,      pos_next;
    logic [31:0] shift_reg,    shift_next;
    logic [31:0] exp_size_reg, exp_size_next;
    logic [1:0]  chans_reg,    chans_next;
    logic [4:0]  bits_reg,     bits_next;
    logic [31:0] rate_reg,     rate_next;
    logic [31:0] brate_reg,    brate_next;
    logic [15:0] align_reg,    align_next;
    logic [31:0] frames_reg,   frames_next;
    logic [7:0]  hold_reg,     hold_next;
    logic        sbi_reg,      sbi_next;
    logic        ch_reg,       ch_next;

    logic [1:0]  cur_phase;
    logic [31:0] cur_shift;
    logic [15:0] half;
    logic [1:0]  frame_shift;
    logic [31:0] frames_calc;
    logic [31:0] frames_dec;
    logic        emit;
    whpd_result_t r;

    always_comb
    begin
        // a start mark restarts the parser with this byte as byte 0
        cur_phase     = start_req ? PH_HEADER : phase_reg;
        cur_shift     = start_req ? 32'd0 : shift_reg;
        pos_next      = start_req ? 6'd0 : pos_reg;
        exp_size_next = start_req ? (file_size - 32'd8) : exp_size_reg;
        chans_next    = start_req ? 2'd1 : chans_reg;
        bits_next     = start_req ? 5'd8 : bits_reg;
        rate_next     = start_req ? 32'd0 : rate_reg;
        brate_next    = start_req ? 32'd0 : brate_reg;
        align_next    = start_req ? 16'd0 : align_reg;
        frames_next   = start_req ? 32'd0 : frames_reg;
        hold_next     = start_req ? 8'd0 : hold_reg;
        sbi_next      = start_req ? 1'b0 : sbi_reg;
        ch_next       = start_req ? 1'b0 : ch_reg;
        phase_next    = cur_phase;
        shift_next    = cur_shift;

        half        = 16'd0;
        frame_shift = 2'd0;
        frames_calc = 32'd0;
        frames_dec  = frames_next - 32'd1;
        emit        = 1'b0;
        r           = '0;

        unique case (cur_phase)
            PH_HEADER:
            begin
                shift_next = {data_byte, cur_shift[31:8]};
                half       = shift_next[31:16];
                pos_next   = pos_next + 6'd1;
                r.kind     = KIND_ERROR;
                case (pos_next - 6'd1)
                    POS_RIFF:
                        if (shift_next != MAGIC_RIFF)
                        begin
                            emit = 1'b1;
                            r.error_code = ERR_RIFF_ID;
                        end
                    POS_SIZE:
                        if (shift_next != exp_size_next)
                        begin
                            emit = 1'b1;
                            r.error_code = ERR_SIZE;
                        end
                    POS_WAVE:
                        if (shift_next != MAGIC_WAVE)
                        begin
                            emit = 1'b1;
                            r.error_code = ERR_WAVE;
                        end
                    POS_FMT:
                        if (shift_next != MAGIC_FMT)
                        begin
                            emit = 1'b1;
                            r.error_code = ERR_FMT_ID;
                        end
                    POS_FORMAT:
                        if (half != 16'd1)
                        begin
                            emit = 1'b1;
                            r.error_code = ERR_FORMAT;
                        end
                    POS_CHANNELS:
                        if (half != 16'd1 && half != 16'd2)
                        begin
                            emit = 1'b1;
                            r.error_code = ERR_CHANNELS;
                        end
                        else
                        begin
                            chans_next = half[1:0];
                        end
                    POS_RATE:
                        rate_next = shift_next;
                    POS_BYTERATE:
                        brate_next = shift_next;
                    POS_ALIGN:
                        align_next = half;
                    POS_BITS:
                        if (half != 16'd8 && half != 16'd16)
                        begin
                            emit = 1'b1;
                            r.error_code = ERR_BITS;
                        end
                        else
                        begin
                            bits_next = half[4:0];
                        end
                    POS_DATA_ID:
                        if (shift_next != MAGIC_DATA)
                        begin
                            emit = 1'b1;
                            r.error_code = ERR_DATA_ID;
                        end
                    POS_LAST:
                    begin
                        // frame is 1, 2 or 4 bytes, so the divide is a shift
                        frame_shift       = {1'b0, chans_next[1]} + {1'b0, bits_next[4]};
                        frames_calc       = shift_next >> frame_shift;
                        frames_next       = frames_calc;
                        emit              = 1'b1;
                        r.kind            = KIND_HEADER;
                        r.channel_count   = chans_next;
                        r.bits_per_sample = bits_next;
                        r.sample_rate     = rate_next;
                        r.byte_rate       = brate_next;
                        r.block_align     = align_next;
                        r.chunk_size      = shift_next;
                        r.last            = (frames_calc == 32'd0);
                        sbi_next          = 1'b0;
                        ch_next           = 1'b0;
                        hold_next         = 8'd0;
                        phase_next        = (frames_calc == 32'd0) ? PH_IDLE : PH_DATA;
                    end
                    default:
                    begin
                    end
                endcase
                if (emit && r.kind == KIND_ERROR)
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_DATA:
            begin
                if (bits_next == 5'd16 && !sbi_next)
                begin
                    hold_next = data_byte;
                    sbi_next  = 1'b1;
                end
                else
                begin
                    emit           = 1'b1;
                    r.kind         = KIND_SAMPLE;
                    r.channel      = ch_next;
                    r.sample_value = (bits_next == 5'd16) ? {data_byte, hold_next}
                                                          : {8'd0, data_byte};
                    sbi_next       = 1'b0;
                    // frame ends on the last channel
                    if (ch_next || chans_next != 2'd2)
                    begin
                        ch_next     = 1'b0;
                        frames_next = frames_dec;
                        if (frames_dec == 32'd0)
                        begin
                            r.last     = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                    else
                    begin
                        ch_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res_valid = fire & emit;
    assign res       = r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            pos_reg      <= 6'd0;
            shift_reg    <= 32'd0;
            exp_size_reg <= 32'd0;
            chans_reg    <= 2'd1;
            bits_reg     <= 5'd8;
            rate_reg     <= 32'd0;
            brate_reg    <= 32'd0;
            align_reg    <= 16'd0;
            frames_reg   <= 32'd0;
            hold_reg     <= 8'd0;
            sbi_reg      <= 1'b0;
            ch_reg       <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            shift_reg    <= shift_next;
            exp_size_reg <= exp_size_next;
            chans_reg    <= chans_next;
            bits_reg     <= bits_next;
            rate_reg     <= rate_next;
            brate_reg    <= brate_next;
            align_reg    <= align_next;
            frames_reg   <= frames_next;
            hold_reg     <= hold_next;
            sbi_reg      <= sbi_next;
            ch_reg       <= ch_next;
        end
    end

endmodule

>>> hdl/whpd_out_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whpd_out_skid
// result register with a skid entry so input stall is fully registered
// ----------------------------------------------------------------------------
module whpd_out_skid
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  whpd_pkg::whpd_result_t push_data,
    output logic                   full,
    output logic                   out_valid,
    input  logic                   out_stall,
    output whpd_pkg::whpd_result_t out_data
);
    import whpd_pkg::*;

    logic         main_valid_reg;
    logic         skid_valid_reg;
    whpd_result_t main_reg;
    whpd_result_t skid_reg;
    logic         out_fire;

    assign out_fire  = main_valid_reg & ~out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || out_fire)
        begin
            // skid is drained first; no push can arrive while it is full
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || out_fire)
        begin
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

endmodule

>>> hdl/whpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whpd_checker
// port-level checks on results of the wav header parser
// ----------------------------------------------------------------------------
module whpd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [2:0]  error_code,
    input logic [1:0]  channel_count,
    input logic [4:0]  bits_per_sample,
    input logic [31:0] chunk_size,
    input logic        last
);
    import whpd_pkg::*;

    // a stalled transaction stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_err_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ERROR |-> !last && channel_count == 2'd0)
        else $error("error result carries header fields or last");

    a_hdr_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_HEADER |->
            (channel_count == 2'd1 || channel_count == 2'd2) &&
            (bits_per_sample == 5'd8 || bits_per_sample == 5'd16) &&
            error_code == ERR_RIFF_ID)
        else $error("header result with bad format fields");

    a_sample_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_SAMPLE |->
            channel_count == 2'd0 && chunk_size == 32'd0 && error_code == ERR_RIFF_ID)
        else $error("sample result carries header fields");

endmodule

bind wav_header_parse_deinterleave whpd_checker u_whpd_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .error_code      (error_code),
    .channel_count   (channel_count),
    .bits_per_sample (bits_per_sample),
    .chunk_size      (chunk_size),
    .last            (last)
);

>>> bench/wav_header_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_header_checker
// watches both channels of the wav header parser, keeps its own copy of the
// parse state, predicts the header, error and sample transactions for every
// accepted byte and compares each accepted result field by field
// ----------------------------------------------------------------------------
module wav_header_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        start_req,
    input  logic [31:0] file_size,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  kind,
    input  logic [2:0]  error_code,
    input  logic        channel,
    input  logic [15:0] sample_value,
    input  logic [1:0]  channel_count,
    input  logic [4:0]  bits_per_sample,
    input  logic [31:0] sample_rate,
    input  logic [31:0] byte_rate,
    input  logic [15:0] block_align,
    input  logic [31:0] chunk_size,
    input  logic        last,
    output int          fail_count,
    output int          pending,
    output int          header_seen,
    output int          error_seen,
    output int          sample_seen
);
    import whpd_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2
    } parse_phase_t;

    parse_phase_t phase;
    logic [5:0]   byte_pos;
    logic [31:0]  shift_reg;
    logic [31:0]  want_riff_size;
    logic [1:0]   hdr_chans;
    logic [4:0]   hdr_bits;
    logic [31:0]  hdr_rate;
    logic [31:0]  hdr_byte_rate;
    logic [15:0]  hdr_align;
    logic [31:0]  frames_left;
    logic [7:0]   low_hold;
    logic         byte_idx;
    logic         cur_chan;

    whpd_result_t expected_q[$];
    whpd_result_t predicted;
    int           result_index;

    function automatic void clear_parser();
        phase          = PH_IDLE;
        byte_pos       = 6'd0;
        shift_reg      = 32'd0;
        want_riff_size = 32'd0;
        hdr_chans      = 2'd1;
        hdr_bits       = 5'd8;
        hdr_rate       = 32'd0;
        hdr_byte_rate  = 32'd0;
        hdr_align      = 16'd0;
        frames_left    = 32'd0;
        low_hold       = 8'd0;
        byte_idx       = 1'b0;
        cur_chan       = 1'b0;
    endfunction

    function automatic bit flag_error(input logic [2:0] code, inout whpd_result_t r);
        r.kind       = KIND_ERROR;
        r.error_code = code;
        phase        = PH_IDLE;
        return 1'b1;
    endfunction

    function automatic bit header_step(input logic [7:0] b, inout whpd_result_t r);
        logic [5:0]  pos;
        logic [15:0] half;
        logic [31:0] frame_bytes;
        pos       = byte_pos;
        shift_reg = {b, shift_reg[31:8]};
        half      = shift_reg[31:16];
        byte_pos  = pos + 6'd1;
        case (pos)
            6'd3:
                if (shift_reg != MAGIC_RIFF)
                    return flag_error(ERR_RIFF_ID, r);
            6'd7:
                if (shift_reg != want_riff_size)
                    return flag_error(ERR_SIZE, r);
            6'd11:
                if (shift_reg != MAGIC_WAVE)
                    return flag_error(ERR_WAVE, r);
            6'd15:
                if (shift_reg != MAGIC_FMT)
                    return flag_error(ERR_FMT_ID, r);
            6'd21:
                if (half != 16'd1)
                    return flag_error(ERR_FORMAT, r);
            6'd23:
            begin
                if (half != 16'd1 && half != 16'd2)
                    return flag_error(ERR_CHANNELS, r);
                hdr_chans = half[1:0];
            end
            6'd27: hdr_rate = shift_reg;
            6'd31: hdr_byte_rate = shift_reg;
            6'd33: hdr_align = half;
            6'd35:
            begin
                if (half != 16'd8 && half != 16'd16)
                    return flag_error(ERR_BITS, r);
                hdr_bits = half[4:0];
            end
            6'd39:
                if (shift_reg != MAGIC_DATA)
                    return flag_error(ERR_DATA_ID, r);
            6'd43:
            begin
                // bytes per frame: channels times 1 or 2
                frame_bytes       = {30'd0, hdr_chans} * {30'd0, hdr_bits[4:3]};
                frames_left       = shift_reg / frame_bytes;
                r.kind            = KIND_HEADER;
                r.channel_count   = hdr_chans;
                r.bits_per_sample = hdr_bits;
                r.sample_rate     = hdr_rate;
                r.byte_rate       = hdr_byte_rate;
                r.block_align     = hdr_align;
                r.chunk_size      = shift_reg;
                r.last            = (frames_left == 32'd0);
                byte_idx          = 1'b0;
                cur_chan          = 1'b0;
                low_hold          = 8'd0;
                phase             = (frames_left == 32'd0) ? PH_IDLE : PH_DATA;
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic bit data_step(input logic [7:0] b, inout whpd_result_t r);
        logic [15:0] value;
        if (hdr_bits == 5'd16 && !byte_idx)
        begin
            low_hold = b;
            byte_idx = 1'b1;
            return 1'b0;
        end
        value          = (hdr_bits == 5'd16) ? {b, low_hold} : {8'd0, b};
        byte_idx       = 1'b0;
        r.kind         = KIND_SAMPLE;
        r.channel      = cur_chan;
        r.sample_value = value;
        if (({1'b0, cur_chan} + 2'd1) >= hdr_chans)
        begin
            cur_chan    = 1'b0;
            frames_left = frames_left - 32'd1;
            if (frames_left == 32'd0)
            begin
                r.last = 1'b1;
                phase  = PH_IDLE;
            end
        end
        else
        begin
            cur_chan = 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic bit predict_byte(input logic [7:0] b, input logic st,
                                        input logic [31:0] fsize, output whpd_result_t r);
        r = '0;
        if (st)
        begin
            clear_parser();
            want_riff_size = fsize - 32'd8;
            phase          = PH_HEADER;
        end
        case (phase)
            PH_HEADER: return header_step(b, r);
            PH_DATA:   return data_step(b, r);
            default:   return 1'b0;
        endcase
    endfunction

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report($sformatf("transaction %0d %s got %0h expected %0h",
                             result_index, name, got, want));
    endtask

    task automatic check_result();
        whpd_result_t want;
        case (kind)
            KIND_SAMPLE: sample_seen++;
            KIND_HEADER: header_seen++;
            default:     error_seen++;
        endcase
        if (expected_q.size() == 0)
        begin
            report($sformatf("transaction %0d of kind %0d with nothing expected",
                             result_index, kind));
        end
        else
        begin
            want = expected_q.pop_front();
            check_field("kind", kind, want.kind);
            check_field("error_code", error_code, want.error_code);
            check_field("channel", channel, want.channel);
            check_field("sample_value", sample_value, want.sample_value);
            check_field("channel_count", channel_count, want.channel_count);
            check_field("bits_per_sample", bits_per_sample, want.bits_per_sample);
            check_field("sample_rate", sample_rate, want.sample_rate);
            check_field("byte_rate", byte_rate, want.byte_rate);
            check_field("block_align", block_align, want.block_align);
            check_field("chunk_size", chunk_size, want.chunk_size);
            check_field("last", last, want.last);
        end
        result_index++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            expected_q.delete();
            pending      = 0;
            fail_count   = 0;
            header_seen  = 0;
            error_seen   = 0;
            sample_seen  = 0;
            result_index = 0;
        end
        else
        begin
            // predict before comparing so a same-edge result would still line up
            if (in_valid && !in_stall)
            begin
                if (predict_byte(data_byte, start_req, file_size, predicted))
                    expected_q.push_back(predicted);
            end
            if (out_valid && !out_stall)
                check_result();
            pending = expected_q.size();
        end
    end

endmodule

>>> bench/wav_header_parse_deinterleave_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_header_parse_deinterleave_tb
// feeds wav files byte by byte: directed headers covering every error code,
// zero-frame and partial-frame files and restarts, then random well-formed
// files mixed with broken, cut and stray bytes, under random idle and stall
// ----------------------------------------------------------------------------
module wav_header_parse_deinterleave_tb;
    import whpd_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int ITEM_TARGET    = 1150;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        start_req = 1'b0;
    logic [31:0] file_size = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [2:0]  error_code;
    logic        channel;
    logic [15:0] sample_value;
    logic [1:0]  channel_count;
    logic [4:0]  bits_per_sample;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [31:0] chunk_size;
    logic        last;

    int fail_count;
    int pending;
    int header_seen;
    int error_seen;
    int sample_seen;

    logic [7:0] file_bytes[$];
    int         bytes_sent;
    int         files_sent;
    int         stuck_cycles;
    bit         sender_fast;
    bit         rx_quiet;
    bit         hold_req;

    always #(CLK_PERIOD / 2) clk = ~clk;

    wav_header_parse_deinterleave uut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .start_req       (start_req),
        .file_size       (file_size),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .error_code      (error_code),
        .channel         (channel),
        .sample_value    (sample_value),
        .channel_count   (channel_count),
        .bits_per_sample (bits_per_sample),
        .sample_rate     (sample_rate),
        .byte_rate       (byte_rate),
        .block_align     (block_align),
        .chunk_size      (chunk_size),
        .last            (last)
    );

    wav_header_checker result_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .start_req       (start_req),
        .file_size       (file_size),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .error_code      (error_code),
        .channel         (channel),
        .sample_value    (sample_value),
        .channel_count   (channel_count),
        .bits_per_sample (bits_per_sample),
        .sample_rate     (sample_rate),
        .byte_rate       (byte_rate),
        .block_align     (block_align),
        .chunk_size      (chunk_size),
        .last            (last),
        .fail_count      (fail_count),
        .pending         (pending),
        .header_seen     (header_seen),
        .error_seen      (error_seen),
        .sample_seen     (sample_seen)
    );

    function automatic logic [31:0] flip_bit(input logic [31:0] v);
        return v ^ (32'd1 << $urandom_range(0, 31));
    endfunction

    // header words lean toward their extremes
    function automatic logic [31:0] pick_word32();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // number of header bytes up to and including the field that fails
    function automatic int error_pos(input logic [2:0] code);
        case (code)
            ERR_RIFF_ID:  return 4;
            ERR_SIZE:     return 8;
            ERR_WAVE:     return 12;
            ERR_FMT_ID:   return 16;
            ERR_FORMAT:   return 22;
            ERR_CHANNELS: return 24;
            ERR_BITS:     return 36;
            default:      return 40;
        endcase
    endfunction

    task automatic push_le(input logic [31:0] v, input int n);
        int i;
        for (i = 0; i < n; i++)
            file_bytes.push_back(v[8 * i +: 8]);
    endtask

    task automatic push_random(input int n);
        int i;
        for (i = 0; i < n; i++)
            file_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic make_file(input logic [31:0] fsize, input logic [15:0] fmt_tag,
                             input logic [15:0] chans, input logic [15:0] bits,
                             input logic [31:0] rate, input logic [31:0] brate,
                             input logic [15:0] align, input logic [31:0] dsize,
                             input bit corrupt, input logic [2:0] code);
        logic [31:0] riff;
        logic [31:0] bad;
        bad = $urandom;
        if (bad == 32'd0)
            bad = 32'd1;
        riff = fsize - 32'd8;
        if (corrupt && code == ERR_SIZE)
            riff = riff ^ bad;
        file_bytes.delete();
        push_le((corrupt && code == ERR_RIFF_ID) ? flip_bit(MAGIC_RIFF) : MAGIC_RIFF, 4);
        push_le(riff, 4);
        push_le((corrupt && code == ERR_WAVE) ? flip_bit(MAGIC_WAVE) : MAGIC_WAVE, 4);
        push_le((corrupt && code == ERR_FMT_ID) ? flip_bit(MAGIC_FMT) : MAGIC_FMT, 4);
        // fmt chunk length is not checked by the parser
        push_le(($urandom_range(0, 3) == 0) ? $urandom : 32'd16, 4);
        push_le({16'd0, fmt_tag}, 2);
        push_le({16'd0, chans}, 2);
        push_le(rate, 4);
        push_le(brate, 4);
        push_le({16'd0, align}, 2);
        push_le({16'd0, bits}, 2);
        push_le((corrupt && code == ERR_DATA_ID) ? flip_bit(MAGIC_DATA) : MAGIC_DATA, 4);
        push_le(dsize, 4);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic st, input logic [31:0] fsize);
        int gap;
        gap = sender_fast ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        start_req <= st;
        file_size <= fsize;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    task automatic send_file(input logic [31:0] fsize, input int n);
        int i;
        int cnt;
        cnt = (n < file_bytes.size()) ? n : file_bytes.size();
        sender_fast = ($urandom_range(0, 3) == 0);
        for (i = 0; i < cnt; i++)
            send_byte(file_bytes[i], i == 0, (i == 0) ? fsize : $urandom);
        files_sent++;
    endtask

    task automatic send_noise(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_byte(8'($urandom_range(0, 255)), 1'b0, $urandom);
    endtask

    // stop offering and wait until every predicted transaction has been taken
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_file();
        int          choice;
        int          chans;
        int          bits;
        int          fb;
        int          n_data;
        int          n;
        logic [31:0] fsize;
        logic [31:0] dsize;
        logic [15:0] fmt_tag;
        logic [2:0]  code;
        bit          corrupt;
        choice  = $urandom_range(0, 99);
        fsize   = pick_word32();
        chans   = $urandom_range(1, 2);
        bits    = $urandom_range(0, 1) ? 16 : 8;
        fb      = chans * bits / 8;
        fmt_tag = 16'd1;
        corrupt = 1'b0;
        if (choice < 70)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // huge data chunk, cut off by the next start
                dsize  = $urandom;
                n_data = $urandom_range(0, 24);
            end
            else
            begin
                dsize  = $urandom_range(0, 12) * fb + $urandom_range(0, fb - 1);
                n_data = dsize + $urandom_range(0, 3);
                if ($urandom_range(0, 9) == 0)
                    n_data = $urandom_range(0, dsize);
            end
            make_file(fsize, fmt_tag, 16'(chans), 16'(bits), pick_word32(), pick_word32(),
                      16'(pick_word32()), dsize, 1'b0, ERR_RIFF_ID);
            push_random(n_data);
            send_file(fsize, 44 + n_data);
        end
        else if (choice < 88)
        begin
            code = 3'($urandom_range(0, 7));
            case (code)
                ERR_FORMAT:
                    do fmt_tag = 16'($urandom); while (fmt_tag == 16'd1);
                ERR_CHANNELS:
                begin
                    if ($urandom_range(0, 1))
                        chans = $urandom_range(0, 1) * 3;
                    else
                        do chans = $urandom_range(0, 65535); while (chans == 1 || chans == 2);
                end
                ERR_BITS:
                begin
                    do bits = $urandom_range(0, 1) ? $urandom_range(0, 32)
                                                   : $urandom_range(0, 65535);
                    while (bits == 8 || bits == 16);
                end
                default: corrupt = 1'b1;
            endcase
            make_file(fsize, fmt_tag, 16'(chans), 16'(bits), pick_word32(), pick_word32(),
                      16'(pick_word32()), $urandom_range(0, 64), corrupt, code);
            // bytes after the failing field are ignored
            n = error_pos(code);
            send_file(fsize, n + $urandom_range(0, 4));
        end
        else if (choice < 95)
        begin
            // header cut short; the next start restarts the parse
            make_file(fsize, fmt_tag, 16'(chans), 16'(bits), pick_word32(), pick_word32(),
                      16'(pick_word32()), $urandom_range(0, 64), 1'b0, ERR_RIFF_ID);
            n = $urandom_range(1, 43);
            send_file(fsize, n);
        end
        else
        begin
            send_noise($urandom_range(1, 4));
        end
    endtask

    // receiver: random stall per transaction, quiet stretches, one long hold
    initial
    begin : receiver
        int k;
        int hold_cnt;
        bit hold_taken;
        hold_taken = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_cnt   = 0;
                out_stall <= 1'b1;
                while (hold_cnt < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    hold_cnt++;
                end
            end
            k = rx_quiet ? 0 : $urandom_range(0, 3);
            if (k > 0)
            begin
                out_stall <= 1'b1;
                repeat (k) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            if ($urandom_range(0, 49) == 0)
                rx_quiet = !rx_quiet;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        bytes_sent   = 0;
        files_sent   = 0;
        sender_fast  = 1'b0;
        hold_req     = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // stray bytes before any start are ignored
        send_noise(2);

        // every error code in turn
        make_file(32'd44, 16'd1, 16'd1, 16'd8, 0, 0, 0, 0, 1'b1, ERR_RIFF_ID);
        send_file(32'd44, error_pos(ERR_RIFF_ID));
        make_file(32'd0, 16'd1, 16'd1, 16'd8, 0, 0, 0, 0, 1'b1, ERR_SIZE);
        send_file(32'd0, error_pos(ERR_SIZE));
        make_file(32'd100, 16'd1, 16'd2, 16'd16, 0, 0, 0, 0, 1'b1, ERR_WAVE);
        send_file(32'd100, error_pos(ERR_WAVE) + 2);
        make_file(32'd100, 16'd1, 16'd2, 16'd16, 0, 0, 0, 0, 1'b1, ERR_FMT_ID);
        send_file(32'd100, error_pos(ERR_FMT_ID));
        make_file(32'd100, 16'hffff, 16'd2, 16'd16, 0, 0, 0, 0, 1'b0, ERR_FORMAT);
        send_file(32'd100, error_pos(ERR_FORMAT));
        make_file(32'd100, 16'd1, 16'd0, 16'd16, 0, 0, 0, 0, 1'b0, ERR_CHANNELS);
        send_file(32'd100, error_pos(ERR_CHANNELS));
        make_file(32'd100, 16'd1, 16'd3, 16'd16, 0, 0, 0, 0, 1'b0, ERR_CHANNELS);
        send_file(32'd100, error_pos(ERR_CHANNELS));
        make_file(32'd100, 16'd1, 16'd1, 16'd24, 0, 0, 0, 0, 1'b0, ERR_BITS);
        send_file(32'd100, error_pos(ERR_BITS));
        make_file(32'd100, 16'd1, 16'd1, 16'd8, 0, 0, 0, 0, 1'b1, ERR_DATA_ID);
        send_file(32'd100, 44);

        // no frames at all, then trailing bytes while idle
        make_file(32'd0, 16'd1, 16'd1, 16'd8, 0, 0, 0, 32'd0, 1'b0, ERR_RIFF_ID);
        push_random(2);
        send_file(32'd0, 46);

        // stereo 16-bit with extreme samples and a partial frame at the end
        make_file(32'hffff_ffff, 16'd1, 16'd2, 16'd16, 32'hffff_ffff, 32'd0,
                  16'hffff, 32'd9, 1'b0, ERR_RIFF_ID);
        push_le(32'hffff_0000, 4);
        push_le(32'h7856_3412, 4);
        push_le(32'h0000_ab9a, 2);
        send_file(32'hffff_ffff, 54);

        // mono 16-bit with a dangling low byte
        make_file(32'd52, 16'd1, 16'd1, 16'd16, 32'd0, 32'hffff_ffff, 16'd0,
                  32'd5, 1'b0, ERR_RIFF_ID);
        push_random(6);
        send_file(32'd52, 50);

        // data chunk smaller than one frame
        make_file(32'd47, 16'd1, 16'd2, 16'd16, 32'd8000, 32'd32000, 16'd4,
                  32'd3, 1'b0, ERR_RIFF_ID);
        push_random(3);
        send_file(32'd47, 47);

        // stereo 8-bit cut in the middle of the data, then a start mid-header
        make_file(32'd48, 16'd1, 16'd2, 16'd8, 32'd44100, 32'd88200, 16'd2,
                  32'd4, 1'b0, ERR_RIFF_ID);
        push_random(4);
        send_file(32'd48, 46);
        make_file(32'd60, 16'd1, 16'd1, 16'd8, 0, 0, 0, 32'd16, 1'b0, ERR_RIFF_ID);
        send_file(32'd60, 20);

        // endless data chunk, interrupted by the next file
        make_file(32'd1000, 16'd1, 16'd1, 16'd8, 0, 0, 0, 32'hffff_ffff,
                  1'b0, ERR_RIFF_ID);
        push_random(5);
        send_file(32'd1000, 49);
        drain();

        // long receiver hold while a long file keeps arriving
        hold_req = 1'b1;
        make_file(32'd204, 16'd1, 16'd2, 16'd16, pick_word32(), pick_word32(),
                  16'(pick_word32()), 32'd160, 1'b0, ERR_RIFF_ID);
        push_random(160);
        send_file(32'd204, 204);

        while (bytes_sent < ITEM_TARGET)
        begin
            random_file();
            if (files_sent % 10 == 3)
                drain();
        end

        drain();
        repeat (8) @(posedge clk);
        $display("covered %0d files in %0d bytes: %0d headers, %0d header errors, %0d samples",
                 files_sent, bytes_sent, header_seen, error_seen, sample_seen);
        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
